### src/kvbe_pkg.sv
// kvbe_pkg: shared types and constants of the keypoint record varbyte encoder
// no dependencies; imported by every module under src

package kvbe_pkg;

	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned HDR_BITS    = 64;
	localparam int unsigned JOB_W       = HDR_BITS + BYTE_W;
	localparam int unsigned CW_W        = 24;
	localparam int unsigned GROUP_BITS  = 7;
	localparam int unsigned VAL_W       = 28;
	localparam int unsigned JOB_DEPTH_DEF = 4;

	localparam logic [3:0] HDR_LAST     = 4'd8;
	localparam logic [3:0] CW_LAST      = 4'd2;
	localparam logic [2:0] HDR_VAL_LAST = 3'd4;

	// one unit of work handed from parser to emitter
	typedef struct packed {
		logic             hdr;   // header record (five values) or a codeword
		logic [JOB_W-1:0] data;  // {x, y, angle, size, count} or codeword in low bits
	} job_t;

	// one result word
	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              value_end;
		logic              run_last;
	} res_t;

endpackage

### src/kvbe_front.sv
// kvbe_front: record parser, takes raw bytes and hands finished values on as jobs
// depends on kvbe_pkg

module kvbe_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept_i,
	input  logic [kvbe_pkg::BYTE_W-1:0] byte_i,
	input  logic                        blob_end_i,
	output logic                        job_valid_o,
	output kvbe_pkg::job_t              job_o
);
	import kvbe_pkg::*;

	logic [HDR_BITS-1:0] hstore_q;
	logic [3:0]          pos_q;
	logic                phase_q;
	logic [BYTE_W-1:0]   left_q;
	logic [15:0]         partial_q;
	logic                hdr_done;
	logic                cw_done;
	logic [BYTE_W-1:0]   left_dec;

	assign hdr_done = !phase_q && (pos_q >= HDR_LAST);
	assign cw_done  = phase_q && (pos_q >= CW_LAST);
	assign left_dec = (left_q != '0) ? left_q - 1'b1 : '0;

	assign job_valid_o = accept_i && (hdr_done || cw_done);
	always_comb begin
		job_o.hdr  = !phase_q;
		job_o.data = phase_q ? {{(JOB_W-CW_W){1'b0}}, partial_q, byte_i}
		                     : {hstore_q, byte_i};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hstore_q  <= '0;
			pos_q     <= '0;
			phase_q   <= 1'b0;
			left_q    <= '0;
			partial_q <= '0;
		end else if (accept_i) begin
			if (blob_end_i) begin
				// end of blob drops any partial header or codeword
				hstore_q  <= '0;
				pos_q     <= '0;
				phase_q   <= 1'b0;
				left_q    <= '0;
				partial_q <= '0;
			end else if (!phase_q) begin
				if (hdr_done) begin
					hstore_q <= '0;
					pos_q    <= '0;
					if (byte_i != '0) begin
						phase_q   <= 1'b1;
						left_q    <= byte_i;
						partial_q <= '0;
					end
				end else begin
					hstore_q <= {hstore_q[HDR_BITS-BYTE_W-1:0], byte_i};
					pos_q    <= pos_q + 1'b1;
				end
			end else begin
				if (cw_done) begin
					partial_q <= '0;
					pos_q     <= '0;
					left_q    <= left_dec;
					if (left_dec == '0)
						phase_q <= 1'b0;
				end else begin
					partial_q <= {partial_q[7:0], byte_i};
					pos_q     <= pos_q + 1'b1;
				end
			end
		end
	end

	a_hdr_pos: assert property (@(posedge clk) disable iff (!arst_n)
		!phase_q |-> pos_q <= HDR_LAST)
		else $error("header position out of range");
	a_cw_pos: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> pos_q <= CW_LAST)
		else $error("codeword position out of range");
	a_blob_end: assert property (@(posedge clk) disable iff (!arst_n)
		(accept_i && blob_end_i) |=> (pos_q == '0) && !phase_q && (left_q == '0))
		else $error("parser not back at header start after blob end");

endmodule

### src/kvbe_jobq.sv
// kvbe_jobq: short job queue between parser and emitter
// depends on kvbe_pkg

module kvbe_jobq #(
	parameter int unsigned DEPTH = kvbe_pkg::JOB_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_i,
	input  kvbe_pkg::job_t data_i,
	output logic           full_o,
	input  logic           pop_i,
	output logic           empty_o,
	output kvbe_pkg::job_t data_o
);
	import kvbe_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wptr_q;
	logic [AW-1:0] rptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full_o  = (cnt_q == CNT_FULL);
	assign empty_o = (cnt_q == '0);
	assign do_push = push_i && !full_o;
	assign do_pop  = pop_i && !empty_o;
	assign data_o  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wptr_q] <= data_i;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push)
				wptr_q <= (wptr_q == PTR_LAST) ? '0 : wptr_q + 1'b1;
			if (do_pop)
				rptr_q <= (rptr_q == PTR_LAST) ? '0 : rptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

### src/kvbe_back.sv
// kvbe_back: emitter, turns each job into varbyte code words one per cycle
// while its two-entry result queue has room; depends on kvbe_pkg

module kvbe_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           jq_empty_i,
	input  kvbe_pkg::job_t jq_data_i,
	output logic           jq_pop_o,
	input  logic           pop_i,
	output logic           empty_o,
	output kvbe_pkg::res_t res_o
);
	import kvbe_pkg::*;

	job_t                 job_q;
	logic                 busy_q;
	logic [2:0]           vidx_q;
	logic [1:0]           grp_q;
	logic                 first_q;
	logic [VAL_W-1:0]     cur_val;
	logic [1:0]           start_grp;
	logic [1:0]           grp_c;
	logic [GROUP_BITS-1:0] grp_bits;
	logic                 last_val;
	logic                 emit;
	logic                 done;
	logic                 load;
	res_t                 res_c;

	res_t                 ofifo_q [2];
	logic                 owptr_q;
	logic                 orptr_q;
	logic [1:0]           ocnt_q;
	logic                 opop;

	// value under work
	always_comb begin
		cur_val = '0;
		if (!job_q.hdr) begin
			cur_val = {{(VAL_W-CW_W){1'b0}}, job_q.data[CW_W-1:0]};
		end else begin
			case (vidx_q)
				3'd0:    cur_val = {{(VAL_W-16){1'b0}}, job_q.data[71:56]};
				3'd1:    cur_val = {{(VAL_W-16){1'b0}}, job_q.data[55:40]};
				3'd2:    cur_val = {{(VAL_W-16){1'b0}}, job_q.data[39:24]};
				3'd3:    cur_val = {{(VAL_W-16){1'b0}}, job_q.data[23:8]};
				default: cur_val = {{(VAL_W-BYTE_W){1'b0}}, job_q.data[7:0]};
			endcase
		end
	end

	// leading zero groups skipped
	always_comb begin
		if (cur_val[27:21] != '0)
			start_grp = 2'd3;
		else if (cur_val[20:14] != '0)
			start_grp = 2'd2;
		else if (cur_val[13:7] != '0)
			start_grp = 2'd1;
		else
			start_grp = 2'd0;
	end

	assign grp_c = first_q ? start_grp : grp_q;

	always_comb begin
		case (grp_c)
			2'd3:    grp_bits = cur_val[27:21];
			2'd2:    grp_bits = cur_val[20:14];
			2'd1:    grp_bits = cur_val[13:7];
			default: grp_bits = cur_val[6:0];
		endcase
	end

	assign last_val = !job_q.hdr || (vidx_q == HDR_VAL_LAST);
	assign emit     = busy_q && (ocnt_q != 2'd2);
	assign done     = emit && (grp_c == 2'd0) && last_val;
	assign load     = !jq_empty_i && (!busy_q || done);
	assign jq_pop_o = load;

	always_comb begin
		res_c.out_byte  = {(grp_c != 2'd0), grp_bits};
		res_c.value_end = (grp_c == 2'd0);
		res_c.run_last  = (grp_c == 2'd0) && last_val;
	end

	always_ff @(posedge clk) begin
		if (load)
			job_q <= jq_data_i;
		if (emit)
			ofifo_q[owptr_q] <= res_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			vidx_q  <= '0;
			grp_q   <= '0;
			first_q <= 1'b1;
		end else if (load) begin
			busy_q  <= 1'b1;
			vidx_q  <= '0;
			first_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (emit) begin
			if (grp_c == 2'd0) begin
				vidx_q  <= vidx_q + 1'b1;
				first_q <= 1'b1;
			end else begin
				grp_q   <= grp_c - 1'b1;
				first_q <= 1'b0;
			end
		end
	end

	assign empty_o = (ocnt_q == 2'd0);
	assign opop    = pop_i && !empty_o;
	assign res_o   = ofifo_q[orptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owptr_q <= 1'b0;
			orptr_q <= 1'b0;
			ocnt_q  <= '0;
		end else begin
			if (emit)
				owptr_q <= ~owptr_q;
			if (opop)
				orptr_q <= ~orptr_q;
			if (emit && !opop)
				ocnt_q <= ocnt_q + 1'b1;
			else if (opop && !emit)
				ocnt_q <= ocnt_q - 1'b1;
		end
	end

	a_ocnt: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q <= 2'd2)
		else $error("result queue overflow");
	a_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty_o && res_o.run_last) |-> res_o.value_end)
		else $error("run end word does not close a value");
	a_vidx: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (vidx_q <= HDR_VAL_LAST))
		else $error("value index past header end");

endmodule

### src/keypoint_record_varbyte_encoder.sv
// keypoint_record_varbyte_encoder: top level of the keypoint record varbyte encoder
// depends on kvbe_pkg, kvbe_front, kvbe_jobq, kvbe_back
//
// channel   direction  handshake            word
// -------   ---------  -------------------  ---------------------------------
// input     in         push / full          in_byte, blob_end
// result    out        empty / pop          out_byte, value_end, run_last
//
// one input word is taken per cycle while the job queue has room; a word that
// completes no value gives no result
// the emitter writes one result word per cycle while the result queue has room; a
// header gives 5 to 14, a codeword 1 to 4, so sustained rate is set by one port
// arst_n clears parser, job queue and result queue at once; no clearing pass
// a stalled result side fills the two-entry result queue, then the job queue,
// and only then raises full

module keypoint_record_varbyte_encoder #(
	parameter int unsigned JOB_DEPTH = kvbe_pkg::JOB_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [kvbe_pkg::BYTE_W-1:0] in_byte,
	input  logic                        blob_end,
	output logic                        empty,
	input  logic                        pop,
	output logic [kvbe_pkg::BYTE_W-1:0] out_byte,
	output logic                        value_end,
	output logic                        run_last
);
	import kvbe_pkg::*;

	logic accept;
	logic job_valid;
	job_t job_in;
	logic jq_full;
	logic jq_empty;
	logic jq_pop;
	job_t jq_data;
	res_t res;

	// whole queue must have room before a byte is taken, completing or not
	assign full   = jq_full;
	assign accept = push && !jq_full;

	kvbe_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept_i    (accept),
		.byte_i      (in_byte),
		.blob_end_i  (blob_end),
		.job_valid_o (job_valid),
		.job_o       (job_in)
	);

	kvbe_jobq #(
		.DEPTH (JOB_DEPTH)
	) u_jobq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push_i  (job_valid),
		.data_i  (job_in),
		.full_o  (jq_full),
		.pop_i   (jq_pop),
		.empty_o (jq_empty),
		.data_o  (jq_data)
	);

	kvbe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.jq_empty_i (jq_empty),
		.jq_data_i  (jq_data),
		.jq_pop_o   (jq_pop),
		.pop_i      (pop),
		.empty_o    (empty),
		.res_o      (res)
	);

	// result word straight from the head of the result queue
	assign out_byte  = res.out_byte;
	assign value_end = res.value_end;
	assign run_last  = res.run_last;

endmodule

### sim/kvbe_sb_pkg.sv
`timescale 1ns / 1ps
// kvbe_sb_pkg: scoreboard for the keypoint record varbyte encoder bench, holding the
// record parser state and the queue of code words still due; depends on kvbe_pkg
package kvbe_sb_pkg;

	import kvbe_pkg::*;

	class varbyte_scoreboard;
		res_t        words_due[$];
		int unsigned mismatches;
		logic [63:0] hdr_bytes;
		logic [3:0]  pos;
		logic        in_codewords;
		logic [7:0]  codewords_left;
		logic [15:0] cw_head;

		function new();
			mismatches = 0;
			clear();
		endfunction

		function void clear();
			hdr_bytes      = '0;
			pos            = '0;
			in_codewords   = 1'b0;
			codewords_left = '0;
			cw_head        = '0;
		endfunction

		// new word at the tail of the due list
		function void add_word(res_t w);
			words_due.insert(words_due.size(), w);
		endfunction

		// most significant group first, leading zero groups skipped
		function void put_value(logic [23:0] v);
			logic [27:0] val;
			logic        started;
			logic [6:0]  grp;
			res_t        w;
			int          g;
			val     = {4'b0, v};
			started = 1'b0;
			w       = '0;
			for (g = 3; g > 0; g--) begin
				grp = val[GROUP_BITS*g +: GROUP_BITS];
				if (grp != 0 || started) begin
					started     = 1'b1;
					w.out_byte  = {1'b1, grp};
					w.value_end = 1'b0;
					add_word(w);
				end
			end
			w.out_byte  = {1'b0, val[6:0]};
			w.value_end = 1'b1;
			add_word(w);
		endfunction

		function void take_word(logic [7:0] b, logic last);
			int unsigned n0;
			n0 = words_due.size();
			if (!in_codewords) begin
				if (pos >= HDR_LAST) begin
					put_value({8'h00, hdr_bytes[63:48]});
					put_value({8'h00, hdr_bytes[47:32]});
					put_value({8'h00, hdr_bytes[31:16]});
					put_value({8'h00, hdr_bytes[15:0]});
					put_value({16'h0000, b});
					hdr_bytes = '0;
					pos       = '0;
					if (b != 0) begin
						in_codewords   = 1'b1;
						codewords_left = b;
						cw_head        = '0;
					end
				end else begin
					hdr_bytes = {hdr_bytes[55:0], b};
					pos++;
				end
			end else begin
				if (pos >= CW_LAST) begin
					put_value({cw_head, b});
					cw_head = '0;
					pos     = '0;
					if (codewords_left != 0)
						codewords_left--;
					if (codewords_left == 0)
						in_codewords = 1'b0;
				end else begin
					cw_head = {cw_head[7:0], b};
					pos++;
				end
			end
			if (last)
				clear();
			if (words_due.size() > n0)
				words_due[words_due.size()-1].run_last = 1'b1;
		endfunction

		function void check_word(logic [7:0] b, logic vend, logic rlast);
			res_t exp_w;
			if (words_due.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected word: byte %02h end %0b last %0b", b, vend, rlast);
				mismatches++;
			end else begin
				exp_w = words_due.pop_front();
				if (exp_w.out_byte !== b || exp_w.value_end !== vend
						|| exp_w.run_last !== rlast) begin
					if (mismatches < 10)
						$display("mismatch: expected byte %02h end %0b last %0b, got %02h %0b %0b",
							exp_w.out_byte, exp_w.value_end, exp_w.run_last, b, vend, rlast);
					mismatches++;
				end
			end
		endfunction

		function int unsigned pending();
			return words_due.size();
		endfunction
	endclass

endpackage

### sim/tb_keypoint_record_varbyte_encoder.sv
`timescale 1ns / 1ps
// tb_keypoint_record_varbyte_encoder: bench top, directed and random record streams
// depends on kvbe_pkg, kvbe_sb_pkg and the keypoint_record_varbyte_encoder rtl
module tb_keypoint_record_varbyte_encoder;

	import kvbe_pkg::*;
	import kvbe_sb_pkg::*;

	localparam int unsigned ITEM_TARGET = 400;
	// longest quiet spell: chained receiver holds plus a sender gap
	localparam int unsigned IDLE_LIMIT  = 2000;
	localparam int unsigned TAIL_CYCLES = 32;

	typedef enum int unsigned {POP_ALWAYS, POP_HALF, POP_SPARSE, POP_HOLD} pop_mode_t;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       push     = 1'b0;
	logic [7:0] in_byte  = '0;
	logic       blob_end = 1'b0;
	logic       pop      = 1'b0;
	logic       full;
	logic       empty;
	logic [7:0] out_byte;
	logic       value_end;
	logic       run_last;

	varbyte_scoreboard sb;
	int unsigned       words_sent = 0;
	int unsigned       burst_left = 0;
	logic [7:0]        blob_q[$];
	pop_mode_t         pop_mode   = POP_ALWAYS;
	int unsigned       pop_left   = 0;

	always #4 clk = ~clk;

	keypoint_record_varbyte_encoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_byte   (in_byte),
		.blob_end  (blob_end),
		.empty     (empty),
		.pop       (pop),
		.out_byte  (out_byte),
		.value_end (value_end),
		.run_last  (run_last)
	);

	// receiver: runs of random length, each with its own appetite for words
	always @(posedge clk) begin
		if (pop_left == 0) begin
			pop_mode = pop_mode_t'($urandom_range(0, 3));
			pop_left = $urandom_range(8, 64);
		end
		pop_left--;
		case (pop_mode)
			POP_ALWAYS: begin
				pop <= 1'b1;
			end
			POP_HALF: begin
				pop <= 1'($urandom_range(0, 1));
			end
			POP_SPARSE: begin
				pop <= ($urandom_range(0, 7) == 0);
			end
			default: begin
				pop <= 1'b0;
			end
		endcase
	end

	// both handshakes are sampled at the edge, before any bench drive lands
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				sb.take_word(in_byte, blob_end);
			if (pop && !empty)
				sb.check_word(out_byte, value_end, run_last);
		end
	end

	// watchdog: too long with neither channel moving a word ends the run
	initial begin
		int unsigned idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				idle = 0;
			else
				idle++;
		end
		$display("[keypoint_record_varbyte_encoder] ERROR");
		$finish;
	end

	// one input word; bursts of random length, most with a gap in front
	task automatic send_word(input logic [7:0] b, input logic last);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		push     <= 1'b1;
		in_byte  <= b;
		blob_end <= last;
		do @(posedge clk); while (full);
		words_sent++;
	endtask

	// big-endian 16-bit header field, never the end of a blob
	task automatic send_field(input logic [15:0] v);
		send_word(v[15:8], 1'b0);
		send_word(v[7:0], 1'b0);
	endtask

	// stop sending and wait for every code word still owed
	task automatic drain();
		push       <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// next byte at the tail of the blob being built
	function automatic void add_byte(input logic [7:0] b);
		blob_q.insert(blob_q.size(), b);
	endfunction

	// random width so that every group count from one to four turns up
	function automatic logic [23:0] spread_value(int unsigned w);
		int unsigned n;
		n = $urandom_range(0, w);
		return 24'($urandom & ((32'd1 << n) - 1));
	endfunction

	// well-formed records with random content; a count too large to send in full
	// ends the blob early, and about one blob in five is cut at a random byte
	task automatic send_blob();
		int unsigned n_rec;
		int unsigned n_cw;
		int unsigned cut;
		logic [7:0]  cnt;
		logic [23:0] v;
		blob_q.delete();
		n_rec = $urandom_range(1, 3);
		for (int r = 0; r < n_rec; r++) begin
			for (int f = 0; f < 4; f++) begin
				v = spread_value(16);
				add_byte(v[15:8]);
				add_byte(v[7:0]);
			end
			case ($urandom_range(0, 9))
				0, 1:    cnt = 8'h00;
				8, 9:    cnt = 8'($urandom);
				default: cnt = 8'($urandom_range(1, 3));
			endcase
			add_byte(cnt);
			n_cw = (cnt > 4) ? $urandom_range(0, 4) : cnt;
			for (int c = 0; c < n_cw; c++) begin
				v = spread_value(24);
				add_byte(v[23:16]);
				add_byte(v[15:8]);
				add_byte(v[7:0]);
			end
			if (n_cw < cnt)
				break;
		end
		if ($urandom_range(0, 4) == 0)
			cut = $urandom_range(1, blob_q.size());
		else
			cut = blob_q.size();
		for (int i = 0; i < cut; i++)
			send_word(blob_q[i], i == cut - 1);
	endtask

	// raw noise with stray blob ends, closed by a blob end to resynchronise
	task automatic send_noise();
		int unsigned len;
		len = $urandom_range(1, 12);
		for (int i = 0; i < len; i++)
			send_word(8'($urandom), ($urandom_range(0, 5) == 0) || (i == len - 1));
	endtask

	initial begin
		bit pressure_done;
		sb            = new();
		pressure_done = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero count: x at zero, y at its maximum, a value just over one group,
		// the largest two-group value, then a count of 0 so the next byte is a header
		send_field(16'h0000);
		send_field(16'hFFFF);
		send_field(16'h0080);
		send_field(16'h3FFF);
		send_word(8'h00, 1'b0);
		// all-ones header with the largest count: fourteen words from one byte
		send_field(16'hFFFF);
		send_field(16'hFFFF);
		send_field(16'hFFFF);
		send_field(16'hFFFF);
		send_word(8'hFF, 1'b0);
		// largest codeword, four groups
		send_word(8'hFF, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(8'hFF, 1'b0);
		// partial codeword dropped at the end of the blob, remaining count forgotten
		send_word(8'h00, 1'b1);
		// header cut off by the end of the blob gives nothing
		send_word(8'h12, 1'b0);
		send_word(8'h34, 1'b0);
		send_word(8'h56, 1'b1);
		drain();

		while (words_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 9) == 0)
				send_noise();
			else
				send_blob();
			// hold the sender once mid-run until the result side has caught up
			if (!pressure_done && words_sent >= ITEM_TARGET / 2) begin
				drain();
				pressure_done = 1'b1;
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("[keypoint_record_varbyte_encoder] OK");
		else
			$display("[keypoint_record_varbyte_encoder] ERROR");
		$finish;
	end

endmodule

### keypoint_record_varbyte_encoder.f
src/kvbe_pkg.sv
src/kvbe_front.sv
src/kvbe_jobq.sv
src/kvbe_back.sv
src/keypoint_record_varbyte_encoder.sv
sim/kvbe_sb_pkg.sv
sim/tb_keypoint_record_varbyte_encoder.sv
